// ===== rtl/core/fpm_pkg.sv =====
// Shared types, constants and helpers of the frame PSNR meter.
package fpm_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int PSNR_W     = 16;
    localparam int ADD_W      = 18;   // three squared 8-bit differences
    localparam int SUM_W      = 42;
    localparam int SCALE_W    = 18;
    localparam int MANT_W     = 31;   // Q1.30 mantissa
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SUM_W-1:0]   SUM_MAX         = {SUM_W{1'b1}};
    localparam logic [SCALE_W-1:0] PEAK_SCALE      = 18'd195075;  // 3 * 255^2
    localparam logic [SCALE_W-1:0] TEN_LOG10_2_Q16 = 18'd197283;
    localparam logic [PSNR_W-1:0]  PSNR_MAX        = {PSNR_W{1'b1}};
    localparam logic [CFG_W-1:0]   WIDTH_RESET     = 13'd1920;
    localparam logic [CFG_W-1:0]   HEIGHT_RESET    = 13'd1080;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0] frame_width;
        logic [CFG_W-1:0] frame_height;
    } fpm_cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CHECK,
        BK_DIM,
        BK_NUM,
        BK_LOGN_GO,
        BK_LOGN_WAIT,
        BK_LOGS_WAIT,
        BK_MUL,
        BK_ROUND,
        BK_WRITE
    } back_state_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_ITER
    } lg_state_t;

    function automatic logic [2*PIX_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (2*PIX_W)'(d) * (2*PIX_W)'(d);
    endfunction

endpackage

// ===== rtl/core/frame_psnr_meter_top.sv =====
// Top level of the frame PSNR meter: config registers, front, queue and back.
//
//   channel   direction  handshake              payload
//   s_*       in         s_valid / s_ready      two RGB pixels, frame_last
//   m_*       out        m_valid / m_ready      psnr_db (Q8.8 dB), frames_identical
//   cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data (13 bits)
//
// Pixel requests are taken one per clock; the front adds the squared channel
// differences in two stages (difference/square, then the 42-bit sum).
// After its last pixel, a frame result is computed by the back end with the
// shared log2 unit (one squaring per fraction bit).
// The front stalls only when a last pixel finds the two-entry sum queue full.
// Reset (aresetn low, synchronous) clears the sum, the queue, both sequencers
// and restores frame_width 1920, frame_height 1080; no clearing pass is needed.
module frame_psnr_meter_top #(
    parameter int MAX_DIMENSION     = 4096,
    parameter int LOG_FRACTION_BITS = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pixel requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [fpm_pkg::PIX_W-1:0]     s_first_red,
    input  logic [fpm_pkg::PIX_W-1:0]     s_first_green,
    input  logic [fpm_pkg::PIX_W-1:0]     s_first_blue,
    input  logic [fpm_pkg::PIX_W-1:0]     s_second_red,
    input  logic [fpm_pkg::PIX_W-1:0]     s_second_green,
    input  logic [fpm_pkg::PIX_W-1:0]     s_second_blue,
    input  logic                          s_frame_last,
    // frame results
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fpm_pkg::PSNR_W-1:0]    m_psnr_db,
    output logic                          m_frames_identical,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fpm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpm_pkg::CFG_W-1:0]     cfg_data
);
    import fpm_pkg::*;

    fpm_cfg_t          cfg_reg;
    logic              q_push_valid;
    logic              q_push_ready;
    logic [SUM_W-1:0]  q_push_data;
    logic              q_pop_valid;
    logic              q_pop_ready;
    logic [SUM_W-1:0]  q_pop_data;

    // Register writes are always accepted; unknown indexes drop.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= WIDTH_RESET;
            cfg_reg.frame_height <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                CFG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: accept pixels and accumulate; hand each frame sum to the queue.
    fpm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_red    (s_first_red),
        .s_first_green  (s_first_green),
        .s_first_blue   (s_first_blue),
        .s_second_red   (s_second_red),
        .s_second_green (s_second_green),
        .s_second_blue  (s_second_blue),
        .s_frame_last   (s_frame_last),
        .q_push_valid   (q_push_valid),
        .q_push_ready   (q_push_ready),
        .q_push_data    (q_push_data)
    );

    // Decouple the pixel path from the per-frame log computation.
    fpm_queue #(
        .WIDTH (SUM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // Back: turn each frame sum into PSNR and hold it in the result register.
    fpm_back #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .LFB           (LOG_FRACTION_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .q_pop_valid        (q_pop_valid),
        .q_pop_ready        (q_pop_ready),
        .q_pop_data         (q_pop_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_psnr_db          (m_psnr_db),
        .m_frames_identical (m_frames_identical)
    );

endmodule

// ===== rtl/core/fpm_queue.sv =====
// Small register FIFO that carries frame sums from the front to the back.
module fpm_queue #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/fpm_front.sv =====
// Pixel front end: squared channel differences and the running frame sum.
module fpm_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [fpm_pkg::PIX_W-1:0]  s_first_red,
    input  logic [fpm_pkg::PIX_W-1:0]  s_first_green,
    input  logic [fpm_pkg::PIX_W-1:0]  s_first_blue,
    input  logic [fpm_pkg::PIX_W-1:0]  s_second_red,
    input  logic [fpm_pkg::PIX_W-1:0]  s_second_green,
    input  logic [fpm_pkg::PIX_W-1:0]  s_second_blue,
    input  logic                       s_frame_last,
    output logic                       q_push_valid,
    input  logic                       q_push_ready,
    output logic [fpm_pkg::SUM_W-1:0]  q_push_data
);
    import fpm_pkg::*;

    logic             s1_valid_reg;
    logic             s1_last_reg;
    logic [ADD_W-1:0] s1_add_reg, s1_add_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W:0]   acc_wide;
    logic [SUM_W-1:0] acc_sat;
    logic             s1_go;

    assign s1_add_next = ADD_W'(sq_diff(s_first_red, s_second_red))
                       + ADD_W'(sq_diff(s_first_green, s_second_green))
                       + ADD_W'(sq_diff(s_first_blue, s_second_blue));

    // Saturate the frame sum instead of wrapping.
    assign acc_wide = {1'b0, sum_reg} + (SUM_W + 1)'(s1_add_reg);
    assign acc_sat  = acc_wide[SUM_W] ? SUM_MAX : acc_wide[SUM_W-1:0];

    // A last pixel leaves stage 1 only when the queue has room.
    assign s1_go        = s1_valid_reg && (!s1_last_reg || q_push_ready);
    assign s_ready      = !s1_valid_reg || s1_go;
    assign q_push_valid = s1_valid_reg && s1_last_reg;
    assign q_push_data  = acc_sat;
    assign sum_next     = s1_last_reg ? '0 : acc_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            sum_reg      <= '0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_go) begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_add_reg  <= s1_add_next;
            s1_last_reg <= s_frame_last;
        end
    end

endmodule

// ===== rtl/core/fpm_log2.sv =====
// Iterative fixed-point log2: leading-one normalize, then repeated squaring.
module fpm_log2 #(
    parameter int LOG_W = 44,
    parameter int LFB   = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [LOG_W-1:0]              x_in,
    output logic                          done,
    output logic [$clog2(LOG_W)+LFB-1:0]  result
);
    import fpm_pkg::*;

    localparam int P_W  = $clog2(LOG_W);
    localparam int IT_W = $clog2(LFB);

    lg_state_t          state_reg, state_next;
    logic [LOG_W-1:0]   x_reg;
    logic [P_W-1:0]     lz_reg;
    logic [MANT_W-1:0]  y_reg;
    logic [LFB-1:0]     frac_reg;
    logic [IT_W-1:0]    iter_reg;
    logic               done_reg;
    logic [2*MANT_W-1:0] sq_full;
    logic [MANT_W:0]    sq_q;
    logic               top_zero8;
    logic               last_iter;

    assign sq_full   = (2*MANT_W)'(y_reg) * (2*MANT_W)'(y_reg);
    assign sq_q      = sq_full[2*MANT_W-1:MANT_W-1];
    assign top_zero8 = (x_reg[LOG_W-1 -: 8] == '0);
    assign last_iter = (iter_reg == IT_W'(LFB - 1));

    assign done   = done_reg;
    assign result = {P_W'(LOG_W - 1) - lz_reg, frac_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LG_IDLE: if (start) state_next = LG_NORM;
            LG_NORM: if (x_reg[LOG_W-1]) state_next = LG_ITER;
            LG_ITER: if (last_iter) state_next = LG_IDLE;
            default: state_next = LG_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == LG_ITER) && last_iter;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            LG_IDLE: begin
                if (start) begin
                    x_reg  <= x_in;
                    lz_reg <= '0;
                end
            end
            LG_NORM: begin
                if (x_reg[LOG_W-1]) begin
                    y_reg    <= x_reg[LOG_W-1 -: MANT_W];
                    frac_reg <= '0;
                    iter_reg <= '0;
                end else if (top_zero8) begin
                    x_reg  <= x_reg << 8;
                    lz_reg <= lz_reg + P_W'(8);
                end else begin
                    x_reg  <= x_reg << 1;
                    lz_reg <= lz_reg + 1'b1;
                end
            end
            LG_ITER: begin
                // Square; a result at or above 2.0 is halved and yields a one bit.
                if (sq_q[MANT_W]) begin
                    y_reg    <= sq_q[MANT_W:1];
                    frac_reg <= {frac_reg[LFB-2:0], 1'b1};
                end else begin
                    y_reg    <= sq_q[MANT_W-1:0];
                    frac_reg <= {frac_reg[LFB-2:0], 1'b0};
                end
                iter_reg <= iter_reg + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/fpm_back.sv =====
// Frame back end: peak term, two logs, dB scaling and the result register.
module fpm_back #(
    parameter int MAX_DIMENSION = 4096,
    parameter int LFB           = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fpm_pkg::fpm_cfg_t           cfg,
    input  logic                        q_pop_valid,
    output logic                        q_pop_ready,
    input  logic [fpm_pkg::SUM_W-1:0]   q_pop_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [fpm_pkg::PSNR_W-1:0]  m_psnr_db,
    output logic                        m_frames_identical
);
    import fpm_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int WH_W   = 2 * DIM_W;
    localparam int NUM_W  = WH_W + SCALE_W;
    localparam int LOG_W  = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int P_W    = $clog2(LOG_W);
    localparam int RES_W  = P_W + LFB;
    localparam int PROD_W = RES_W + SCALE_W;
    localparam int SHIFT  = LFB + 8;
    localparam logic [PROD_W:0] ROUND_ONE = (PROD_W + 1)'(1) << (SHIFT - 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CFG_W:0] wide;
        wide = (CFG_W + 1)'(d);
        if (wide > (CFG_W + 1)'(MAX_DIMENSION)) begin
            wide = (CFG_W + 1)'(MAX_DIMENSION);
        end
        return DIM_W'(wide);
    endfunction

    back_state_t        state_reg, state_next;
    logic [SUM_W-1:0]   sum_reg;
    logic [WH_W-1:0]    wh_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [RES_W-1:0]   ln_reg;
    logic [RES_W-1:0]   diff_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PSNR_W-1:0]  psnr_reg;
    logic               ident_reg;
    logic               m_valid_reg;
    logic [PSNR_W-1:0]  m_psnr_reg;
    logic               m_ident_reg;

    logic               lg_start;
    logic [LOG_W-1:0]   lg_x;
    logic               lg_done;
    logic [RES_W-1:0]   lg_result;
    logic               out_free;
    logic               out_load;
    logic               num_zero;
    logic [PROD_W:0]    rounded;
    logic [PROD_W-SHIFT:0] scaled;
    logic [PSNR_W-1:0]  psnr_sat;

    fpm_log2 #(
        .LOG_W (LOG_W),
        .LFB   (LFB)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lg_start),
        .x_in    (lg_x),
        .done    (lg_done),
        .result  (lg_result)
    );

    assign num_zero = (num_reg == '0);
    assign out_free = !m_valid_reg || m_ready;
    assign lg_x     = (state_reg == BK_LOGN_GO) ? LOG_W'(num_reg) : LOG_W'(sum_reg);
    assign rounded  = {1'b0, prod_reg} + ROUND_ONE;
    assign scaled   = rounded[PROD_W:SHIFT];
    assign psnr_sat = (|scaled[PROD_W-SHIFT:PSNR_W]) ? PSNR_MAX : scaled[PSNR_W-1:0];

    assign m_valid            = m_valid_reg;
    assign m_psnr_db          = m_psnr_reg;
    assign m_frames_identical = m_ident_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:      if (q_pop_valid) state_next = BK_CHECK;
            BK_CHECK:     state_next = (sum_reg == '0) ? BK_WRITE : BK_DIM;
            BK_DIM:       state_next = BK_NUM;
            BK_NUM:       state_next = BK_LOGN_GO;
            BK_LOGN_GO:   state_next = num_zero ? BK_WRITE : BK_LOGN_WAIT;
            BK_LOGN_WAIT: if (lg_done) state_next = BK_LOGS_WAIT;
            BK_LOGS_WAIT: begin
                if (lg_done) begin
                    state_next = (ln_reg > lg_result) ? BK_MUL : BK_WRITE;
                end
            end
            BK_MUL:       state_next = BK_ROUND;
            BK_ROUND:     state_next = BK_WRITE;
            BK_WRITE:     if (out_free) state_next = BK_IDLE;
            default:      state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop_ready = 1'b0;
        lg_start    = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            BK_IDLE:      q_pop_ready = 1'b1;
            BK_LOGN_GO:   lg_start = !num_zero;
            BK_LOGN_WAIT: lg_start = lg_done;
            BK_WRITE:     out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                if (q_pop_valid) begin
                    sum_reg <= q_pop_data;
                end
            end
            BK_CHECK: begin
                psnr_reg  <= PSNR_MAX;
                ident_reg <= 1'b1;
            end
            BK_DIM: begin
                wh_reg    <= WH_W'(clamp_dim(cfg.frame_width))
                           * WH_W'(clamp_dim(cfg.frame_height));
                psnr_reg  <= '0;
                ident_reg <= 1'b0;
            end
            BK_NUM:       num_reg <= NUM_W'(wh_reg) * NUM_W'(PEAK_SCALE);
            BK_LOGN_WAIT: if (lg_done) ln_reg <= lg_result;
            BK_LOGS_WAIT: if (lg_done) diff_reg <= ln_reg - lg_result;
            BK_MUL:       prod_reg <= PROD_W'(diff_reg) * PROD_W'(TEN_LOG10_2_Q16);
            BK_ROUND:     psnr_reg <= psnr_sat;
            default: ;
        endcase
        if (out_load) begin
            m_psnr_reg  <= psnr_reg;
            m_ident_reg <= ident_reg;
        end
    end

endmodule

// ===== rtl/core/fpm_checker.sv =====
// Port-level assertions for the frame PSNR meter, bound to the top level.
module fpm_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [fpm_pkg::PSNR_W-1:0] m_psnr_db,
    input logic                       m_frames_identical
);
    import fpm_pkg::*;

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_psnr_db) && $stable(m_frames_identical))
        else $error("result changed while stalled");

    // Identical frames report the maximum code.
    a_identical_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frames_identical |-> m_psnr_db == PSNR_MAX)
        else $error("identical frames without maximum code");

    // Reset empties the result register and the pixel stage.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the datapath");

endmodule

bind frame_psnr_meter_top fpm_checker u_fpm_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_psnr_db          (m_psnr_db),
    .m_frames_identical (m_frames_identical)
);
